@@ hdl/bdl_pkg.sv @@
`timescale 1ns / 1ps

package bdl_pkg;

    // input actions
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;

    // register map
    localparam logic [2:0] REG_SELECT   = 3'd0;
    localparam logic [2:0] REG_MODE     = 3'd1;
    localparam logic [2:0] REG_PTR_LO   = 3'd2;
    localparam logic [2:0] REG_PTR_HI   = 3'd3;
    localparam logic [2:0] REG_BANK_LO  = 3'd4;
    localparam logic [2:0] REG_BANK_HI  = 3'd5;
    localparam logic [2:0] REG_COUNT_LO = 3'd6;
    localparam logic [2:0] REG_COUNT_HI = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_RDATA = 2'd0;
    localparam logic [1:0] KIND_MRD   = 2'd1;
    localparam logic [1:0] KIND_MWR   = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // pointer modes and logic functions
    localparam logic [1:0] PMODE_RELOAD = 2'd1;
    localparam logic [1:0] FN_COPY      = 2'd0;
    localparam logic [1:0] FN_XOR       = 2'd1;
    localparam logic [1:0] FN_OR        = 2'd2;
    localparam logic [1:0] FN_AND       = 2'd3;

    localparam logic [15:0] PTR_TOP_BIT = 16'h8000;
    localparam logic [15:0] PTR_MAX     = 16'hFFFF;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SRC  = 3'b010,
        PH_DST  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  read_byte;
        logic [15:0] mem_bank;
        logic [15:0] mem_addr;
        logic [7:0]  mem_wdata;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] rb,
                                    input logic [15:0] bank, input logic [15:0] addr,
                                    input logic [7:0] wd, input logic last);
        res_t r;
        r.kind      = kind;
        r.read_byte = rb;
        r.mem_bank  = bank;
        r.mem_addr  = addr;
        r.mem_wdata = wd;
        r.last      = last;
        return r;
    endfunction

    function automatic logic [15:0] step_ptr(input logic [15:0] p);
        return (p + 16'd1) | PTR_TOP_BIT;
    endfunction

    function automatic logic [15:0] step_bank(input logic [15:0] b, input logic [15:0] p);
        return (p == PTR_MAX) ? (b + 16'd1) : b;
    endfunction

endpackage

@@ hdl/byte_dma_with_logic_ops_unit.sv @@
`timescale 1ns / 1ps

// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | action, reg_index, write_byte, mem_byte
// m_      | out       | m_valid / m_ready  | kind, read_byte, mem_bank, mem_addr,
//         |           |                    | mem_wdata, last
//
// one request is taken per cycle while s_ready is high; it is held in the input
// register, where the engine state and its results are worked out, then its
// results enter a four-entry result queue that drives m_. a memory data return
// in the destination phase gives two results, so under a steady stream of those
// the output port, which passes one result at a time, limits the request rate.
// aresetn is synchronous, active low, and clears all engine registers. s_ready
// drops only while a request is held and the queue lacks room for two results.

module byte_dma_with_logic_ops_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [2:0]  s_reg_index,
    input  logic [7:0]  s_write_byte,
    input  logic [7:0]  s_mem_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_read_byte,
    output logic [15:0] m_mem_bank,
    output logic [15:0] m_mem_addr,
    output logic [7:0]  m_mem_wdata,
    output logic        m_last
);
    import bdl_pkg::*;

    // input register
    logic       in_vld_reg;
    logic [1:0] action_reg;
    logic [2:0] index_reg;
    logic [7:0] wbyte_reg;
    logic [7:0] mbyte_reg;

    logic  room2;
    logic  proc_en;
    push_t push;
    res_t  head;

    // the held request is worked once the queue can take both of its results
    assign proc_en = in_vld_reg && room2;
    assign s_ready = !in_vld_reg || room2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            index_reg  <= s_reg_index;
            wbyte_reg  <= s_write_byte;
            mbyte_reg  <= s_mem_byte;
        end
    end

    // register file, sequencer and logic function
    bdl_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (proc_en),
        .action     (action_reg),
        .reg_index  (index_reg),
        .write_byte (wbyte_reg),
        .mem_byte   (mbyte_reg),
        .push       (push)
    );

    // result queue decouples the two sides
    bdl_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room2     (room2),
        .pop       (m_valid && m_ready),
        .out_valid (m_valid),
        .out_item  (head)
    );

    assign m_kind      = head.kind;
    assign m_read_byte = head.read_byte;
    assign m_mem_bank  = head.mem_bank;
    assign m_mem_addr  = head.mem_addr;
    assign m_mem_wdata = head.mem_wdata;
    assign m_last      = head.last;

endmodule

@@ hdl/bdl_core.sv @@
`timescale 1ns / 1ps

module bdl_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic [1:0]     action,
    input  logic [2:0]     reg_index,
    input  logic [7:0]     write_byte,
    input  logic [7:0]     mem_byte,
    output bdl_pkg::push_t push
);
    import bdl_pkg::*;

    logic [7:0]  select_reg, select_next;
    logic [5:0]  mode_reg, mode_next;
    logic [15:0] src_ptr_reg, src_ptr_next;
    logic [15:0] dst_ptr_reg, dst_ptr_next;
    logic [15:0] src_bank_reg, src_bank_next;
    logic [15:0] dst_bank_reg, dst_bank_next;
    logic [15:0] count_reg, count_next;
    logic [16:0] left_reg, left_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] saved_src_reg, saved_src_next;
    logic [15:0] saved_dst_reg, saved_dst_next;
    logic [7:0]  held_reg, held_next;

    logic        dst_sel;
    logic [15:0] sel_ptr, sel_bank;
    logic [7:0]  rd_byte;
    logic [7:0]  func_byte;
    logic [1:0]  smode, dmode, func;

    assign dst_sel  = select_reg[0];
    assign sel_ptr  = dst_sel ? dst_ptr_reg : src_ptr_reg;
    assign sel_bank = dst_sel ? dst_bank_reg : src_bank_reg;
    assign smode    = mode_reg[1:0];
    assign dmode    = mode_reg[3:2];
    assign func     = mode_reg[5:4];

    always_comb begin
        unique case (reg_index)
            REG_SELECT:   rd_byte = select_reg;
            REG_MODE:     rd_byte = {2'b00, mode_reg};
            REG_PTR_LO:   rd_byte = sel_ptr[7:0];
            REG_PTR_HI:   rd_byte = sel_ptr[15:8];
            REG_BANK_LO:  rd_byte = sel_bank[7:0];
            REG_BANK_HI:  rd_byte = sel_bank[15:8];
            REG_COUNT_LO: rd_byte = count_reg[7:0];
            REG_COUNT_HI: rd_byte = count_reg[15:8];
            default:      rd_byte = '0;
        endcase
    end

    always_comb begin
        case (func)
            FN_COPY: func_byte = held_reg;
            FN_XOR:  func_byte = held_reg ^ mem_byte;
            FN_OR:   func_byte = held_reg | mem_byte;
            FN_AND:  func_byte = held_reg & mem_byte;
            default: func_byte = held_reg;
        endcase
    end

    always_comb begin
        select_next    = select_reg;
        mode_next      = mode_reg;
        src_ptr_next   = src_ptr_reg;
        dst_ptr_next   = dst_ptr_reg;
        src_bank_next  = src_bank_reg;
        dst_bank_next  = dst_bank_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        phase_next     = phase_reg;
        saved_src_next = saved_src_reg;
        saved_dst_next = saved_dst_reg;
        held_next      = held_reg;
        push           = '0;
        if (en) begin
            unique case (action)
                ACT_WRITE: begin
                    if (phase_reg == PH_IDLE) begin
                        unique case (reg_index)
                            REG_SELECT: select_next = write_byte;
                            REG_MODE:   mode_next = write_byte[5:0];
                            REG_PTR_LO: begin
                                if (dst_sel) dst_ptr_next = {dst_ptr_reg[15:8], write_byte};
                                else src_ptr_next = {src_ptr_reg[15:8], write_byte};
                            end
                            REG_PTR_HI: begin
                                // top bit of the pointer always set on a write
                                if (dst_sel) begin
                                    dst_ptr_next = {1'b1, write_byte[6:0], dst_ptr_reg[7:0]};
                                end else begin
                                    src_ptr_next = {1'b1, write_byte[6:0], src_ptr_reg[7:0]};
                                end
                            end
                            REG_BANK_LO: begin
                                if (dst_sel) dst_bank_next = {dst_bank_reg[15:8], write_byte};
                                else src_bank_next = {src_bank_reg[15:8], write_byte};
                            end
                            REG_BANK_HI: begin
                                if (dst_sel) dst_bank_next = {write_byte, dst_bank_reg[7:0]};
                                else src_bank_next = {write_byte, src_bank_reg[7:0]};
                            end
                            REG_COUNT_LO: count_next = {count_reg[15:8], write_byte};
                            REG_COUNT_HI: begin
                                count_next     = {write_byte, count_reg[7:0]};
                                left_next      = {1'b0, count_next} + 17'd1;
                                saved_src_next = src_ptr_reg;
                                saved_dst_next = dst_ptr_reg;
                                phase_next     = PH_SRC;
                                push.cnt       = 2'd1;
                                push.r0        = mk_res(KIND_MRD, 8'd0, src_bank_reg,
                                                        src_ptr_reg, 8'd0, 1'b1);
                            end
                            default: ;
                        endcase
                    end
                end
                ACT_READ: begin
                    if (phase_reg == PH_IDLE) begin
                        push.cnt = 2'd1;
                        push.r0  = mk_res(KIND_RDATA, rd_byte, 16'd0, 16'd0, 8'd0, 1'b1);
                    end
                end
                ACT_DATA: begin
                    if (phase_reg == PH_SRC) begin
                        held_next  = mem_byte;
                        phase_next = PH_DST;
                        push.cnt   = 2'd1;
                        push.r0    = mk_res(KIND_MRD, 8'd0, dst_bank_reg, dst_ptr_reg,
                                            8'd0, 1'b1);
                    end else if (phase_reg == PH_DST) begin
                        push.cnt = 2'd2;
                        push.r0  = mk_res(KIND_MWR, 8'd0, dst_bank_reg, dst_ptr_reg,
                                          func_byte, 1'b0);
                        if (!smode[1]) begin
                            src_bank_next = step_bank(src_bank_reg, src_ptr_reg);
                            src_ptr_next  = step_ptr(src_ptr_reg);
                        end
                        if (!dmode[1]) begin
                            dst_bank_next = step_bank(dst_bank_reg, dst_ptr_reg);
                            dst_ptr_next  = step_ptr(dst_ptr_reg);
                        end
                        left_next = left_reg - 17'd1;
                        if (left_next != 17'd0) begin
                            phase_next = PH_SRC;
                            push.r1    = mk_res(KIND_MRD, 8'd0, src_bank_next, src_ptr_next,
                                                8'd0, 1'b1);
                        end else begin
                            if (smode == PMODE_RELOAD) src_ptr_next = saved_src_reg;
                            if (dmode == PMODE_RELOAD) dst_ptr_next = saved_dst_reg;
                            phase_next = PH_IDLE;
                            push.r1    = mk_res(KIND_DONE, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_reg    <= '0;
            mode_reg      <= '0;
            src_ptr_reg   <= '0;
            dst_ptr_reg   <= '0;
            src_bank_reg  <= '0;
            dst_bank_reg  <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            phase_reg     <= PH_IDLE;
            saved_src_reg <= '0;
            saved_dst_reg <= '0;
            held_reg      <= '0;
        end else begin
            select_reg    <= select_next;
            mode_reg      <= mode_next;
            src_ptr_reg   <= src_ptr_next;
            dst_ptr_reg   <= dst_ptr_next;
            src_bank_reg  <= src_bank_next;
            dst_bank_reg  <= dst_bank_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            phase_reg     <= phase_next;
            saved_src_reg <= saved_src_next;
            saved_dst_reg <= saved_dst_next;
            held_reg      <= held_next;
        end
    end

    // an engine that returns to idle from the destination phase has nothing left to move
    a_idle_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE && $past(phase_reg) == PH_DST) |-> left_reg == 17'd0)
        else $error("transfer run ended with requests left");

    // a run always starts with a source request
    a_start_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(phase_reg) == PH_IDLE && phase_reg != PH_IDLE) |-> phase_reg == PH_SRC)
        else $error("transfer run started outside the source phase");

    // the write of a transfer is always followed by a second result
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt != 2'd0 && push.r0.kind == KIND_MWR) |-> push.cnt == 2'd2)
        else $error("memory write without a following result");

endmodule

@@ hdl/bdl_out_fifo.sv @@
`timescale 1ns / 1ps

module bdl_out_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  bdl_pkg::push_t push,
    output logic           room2,
    input  logic           pop,
    output logic           out_valid,
    output bdl_pkg::res_t  out_item
);
    import bdl_pkg::*;

    res_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [FIFO_AW-1:0] wr_ptr_p1;

    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign room2     = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push.cnt) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) mem[wr_ptr_reg] <= push.r0;
        if (push.cnt == 2'd2) mem[wr_ptr_p1] <= push.r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt != 2'd0 |-> (count_reg + FIFO_CW'(push.cnt)) <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("result queue underflow");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push.cnt == 2'd0) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("result queue count lost a pop");

endmodule

@@ verif/tb_byte_dma_with_logic_ops_unit.sv @@
`timescale 1ns / 1ps

module tb_byte_dma_with_logic_ops_unit;

    import bdl_pkg::*;

    // codes the package leaves out
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam logic [1:0] PM_CONTINUE  = 2'd0;
    localparam logic [1:0] PM_FIXED     = 2'd2;
    localparam logic [1:0] PM_FIXED_ALT = 2'd3;
    localparam logic [7:0] SEL_SRC      = 8'h00;
    localparam logic [7:0] SEL_DST      = 8'h01;

    // no accepted request on either side for this long means the block has hung
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 1100;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [2:0]  s_reg_index;
    logic [7:0]  s_write_byte;
    logic [7:0]  s_mem_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [7:0]  m_read_byte;
    logic [15:0] m_mem_bank;
    logic [15:0] m_mem_addr;
    logic [7:0]  m_mem_wdata;
    logic        m_last;

    byte_dma_with_logic_ops_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_reg_index  (s_reg_index),
        .s_write_byte (s_write_byte),
        .s_mem_byte   (s_mem_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_read_byte  (m_read_byte),
        .m_mem_bank   (m_mem_bank),
        .m_mem_addr   (m_mem_addr),
        .m_mem_wdata  (m_mem_wdata),
        .m_last       (m_last)
    );

    // 12 ns period, starting low so no edge falls at time zero
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // -------------------------------------------------------------------------
    // engine state as the checker sees it; updated as each request is accepted
    // -------------------------------------------------------------------------
    logic [7:0]  sel_q         = '0;
    logic [5:0]  mode_q        = '0;
    logic [15:0] src_ptr       = '0;
    logic [15:0] dst_ptr       = '0;
    logic [15:0] src_bnk       = '0;
    logic [15:0] dst_bnk       = '0;
    logic [15:0] count_q       = '0;
    logic [16:0] moves_left    = '0;
    phase_t      phase_q       = PH_IDLE;
    logic [15:0] src_ptr_start = '0;
    logic [15:0] dst_ptr_start = '0;
    logic [7:0]  src_byte_hold = '0;

    // bus results still owed by the block, oldest first
    res_t dma_results_due[$];

    int   error_count = 0;
    int   items_moved = 0;

    // handshake between the test sequence and the result sink
    bit   quiet            = 1'b0;
    bit   hold_results_req = 1'b0;
    bit   hold_active      = 1'b0;
    // level last driven onto s_valid, so it is only lowered when it is high
    bit   offer_up         = 1'b0;

    function automatic void owe_result(input logic [1:0] kind, input logic [7:0] rb,
                                       input logic [15:0] bank, input logic [15:0] addr,
                                       input logic [7:0] wd, input logic last);
        res_t r;
        r.kind      = kind;
        r.read_byte = rb;
        r.mem_bank  = bank;
        r.mem_addr  = addr;
        r.mem_wdata = wd;
        r.last      = last;
        dma_results_due.push_back(r);
    endfunction

    // continue and reload step the pointer, spilling into the bank past 0xffff;
    // both fixed codes leave the side alone
    function automatic void advance_side(input logic [1:0] pmode, inout logic [15:0] ptr,
                                         inout logic [15:0] bank);
        if (pmode == PM_FIXED || pmode == PM_FIXED_ALT) return;
        if (ptr == PTR_MAX) bank = bank + 16'd1;
        ptr = (ptr + 16'd1) | PTR_TOP_BIT;
    endfunction

    function automatic logic [7:0] register_value(input logic [2:0] idx);
        logic [15:0] ptr_sel;
        logic [15:0] bank_sel;
        ptr_sel  = sel_q[0] ? dst_ptr : src_ptr;
        bank_sel = sel_q[0] ? dst_bnk : src_bnk;
        case (idx)
            REG_SELECT:   return sel_q;
            REG_MODE:     return {2'b00, mode_q};
            REG_PTR_LO:   return ptr_sel[7:0];
            REG_PTR_HI:   return ptr_sel[15:8];
            REG_BANK_LO:  return bank_sel[7:0];
            REG_BANK_HI:  return bank_sel[15:8];
            REG_COUNT_LO: return count_q[7:0];
            default:      return count_q[15:8];
        endcase
    endfunction

    // works out what one accepted request does to the engine and which bus
    // results it owes
    function automatic void predict_dma_outputs(input logic [1:0] act, input logic [2:0] idx,
                                                input logic [7:0] wb, input logic [7:0] mb);
        logic       to_dst;
        logic [1:0] fn;
        logic [1:0] smode;
        logic [1:0] dmode;
        logic [7:0] merged;
        to_dst = sel_q[0];
        fn     = mode_q[5:4];
        dmode  = mode_q[3:2];
        smode  = mode_q[1:0];
        case (act)
            ACT_WRITE: begin
                // register writes during a run are dropped
                if (phase_q == PH_IDLE) begin
                    case (idx)
                        REG_SELECT: sel_q = wb;
                        REG_MODE:   mode_q = wb[5:0];
                        REG_PTR_LO: begin
                            if (to_dst) dst_ptr[7:0] = wb;
                            else src_ptr[7:0] = wb;
                        end
                        REG_PTR_HI: begin
                            // the top pointer bit is forced on
                            if (to_dst) dst_ptr = {wb, dst_ptr[7:0]} | PTR_TOP_BIT;
                            else src_ptr = {wb, src_ptr[7:0]} | PTR_TOP_BIT;
                        end
                        REG_BANK_LO: begin
                            if (to_dst) dst_bnk[7:0] = wb;
                            else src_bnk[7:0] = wb;
                        end
                        REG_BANK_HI: begin
                            if (to_dst) dst_bnk[15:8] = wb;
                            else src_bnk[15:8] = wb;
                        end
                        REG_COUNT_LO: count_q[7:0] = wb;
                        default: begin
                            // count hi kicks off count+1 transfers
                            count_q[15:8] = wb;
                            moves_left    = {1'b0, count_q} + 17'd1;
                            src_ptr_start = src_ptr;
                            dst_ptr_start = dst_ptr;
                            phase_q       = PH_SRC;
                            owe_result(KIND_MRD, 8'h00, src_bnk, src_ptr, 8'h00, 1'b1);
                        end
                    endcase
                end
            end
            ACT_READ: begin
                if (phase_q == PH_IDLE)
                    owe_result(KIND_RDATA, register_value(idx), 16'h0, 16'h0, 8'h00, 1'b1);
            end
            ACT_DATA: begin
                if (phase_q == PH_SRC) begin
                    src_byte_hold = mb;
                    phase_q       = PH_DST;
                    owe_result(KIND_MRD, 8'h00, dst_bnk, dst_ptr, 8'h00, 1'b1);
                end else if (phase_q == PH_DST) begin
                    case (fn)
                        FN_COPY: merged = src_byte_hold;
                        FN_XOR:  merged = src_byte_hold ^ mb;
                        FN_OR:   merged = src_byte_hold | mb;
                        default: merged = src_byte_hold & mb;
                    endcase
                    owe_result(KIND_MWR, 8'h00, dst_bnk, dst_ptr, merged, 1'b0);
                    advance_side(smode, src_ptr, src_bnk);
                    advance_side(dmode, dst_ptr, dst_bnk);
                    moves_left = moves_left - 17'd1;
                    if (moves_left != 17'd0) begin
                        phase_q = PH_SRC;
                        owe_result(KIND_MRD, 8'h00, src_bnk, src_ptr, 8'h00, 1'b1);
                    end else begin
                        // reload sides get their start pointer back, banks stay put
                        if (smode == PMODE_RELOAD) src_ptr = src_ptr_start;
                        if (dmode == PMODE_RELOAD) dst_ptr = dst_ptr_start;
                        phase_q = PH_IDLE;
                        owe_result(KIND_DONE, 8'h00, 16'h0, 16'h0, 8'h00, 1'b1);
                    end
                end
                // data with no read outstanding is dropped
            end
            default: ;  // unused action code, dropped
        endcase
    endfunction

    // -------------------------------------------------------------------------
    // result side: compare every accepted result with the oldest one owed
    // -------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        res_t due;
        if (aresetn && m_valid && m_ready) begin
            if (dma_results_due.size() == 0) begin
                $error("unexpected result: kind %0d addr 0x%0h", m_kind, m_mem_addr);
                error_count++;
            end else begin
                due = dma_results_due.pop_front();
                check_field("kind",      due.kind,      m_kind);
                check_field("read_byte", due.read_byte, m_read_byte);
                check_field("mem_bank",  due.mem_bank,  m_mem_bank);
                check_field("mem_addr",  due.mem_addr,  m_mem_addr);
                check_field("mem_wdata", due.mem_wdata, m_mem_wdata);
                check_field("last",      due.last,      m_last);
            end
        end
    end

    // result sink: random ready pattern, one long hold on request, always ready
    // while quiet
    initial begin : result_sink
        int pick;
        m_ready = 1'b0;
        forever begin
            pick = $urandom_range(0, 99);
            if (hold_results_req) begin
                hold_results_req = 1'b0;
                hold_active      = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if (pick < 60) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else if (pick < 70) begin
                // a stretch with no stalls at all
                m_ready <= 1'b1;
                repeat ($urandom_range(30, 80)) @(posedge aclk);
            end else if (pick < 95) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(8, 30)) @(posedge aclk);
            end
        end
    end

    // hang detector: counts cycles with no request accepted on either side
    always @(posedge aclk) begin
        int idle_cycles;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $error("no request accepted for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // request side
    // -------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one request and wait for it to be taken; valid stays up on return
    // so a back-to-back request needs no extra edge
    task automatic issue_request(input logic [1:0] act, input logic [2:0] idx,
                                 input logic [7:0] wb, input logic [7:0] mb);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            if (offer_up) begin
                s_valid <= 1'b0;
                offer_up = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_reg_index  <= idx;
        s_write_byte <= wb;
        s_mem_byte   <= mb;
        offer_up = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_dma_outputs(act, idx, wb, mb);
    endtask

    // drop valid and sit until every owed result has come back
    task automatic wait_drained();
        if (offer_up) begin
            s_valid <= 1'b0;
            offer_up = 1'b0;
        end
        @(posedge aclk);
        while (dma_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        issue_request(ACT_WRITE, idx, val, 8'($urandom));
    endtask

    task automatic read_reg(input logic [2:0] idx);
        issue_request(ACT_READ, idx, 8'($urandom), 8'($urandom));
    endtask

    task automatic return_byte(input logic [7:0] mb);
        issue_request(ACT_DATA, 3'($urandom), 8'($urandom), mb);
    endtask

    // register access or unused code thrown in while a run is going
    task automatic stray_request();
        case ($urandom_range(0, 2))
            0:       issue_request(ACT_WRITE, 3'($urandom), 8'($urandom), 8'($urandom));
            1:       issue_request(ACT_READ, 3'($urandom), 8'($urandom), 8'($urandom));
            default: issue_request(ACT_UNUSED, 3'($urandom), 8'($urandom), 8'($urandom));
        endcase
    endtask

    function automatic logic [7:0] mode_byte(input logic [1:0] fn, input logic [1:0] dmode,
                                             input logic [1:0] smode);
        return {2'b00, fn, dmode, smode};
    endfunction

    // start a run with count hi and answer every memory read until it is done
    task automatic run_transfers(input logic [7:0] count_hi, input int noise_pct);
        write_reg(REG_COUNT_HI, count_hi);
        items_moved++;
        while (phase_q != PH_IDLE) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                stray_request();
            end else begin
                return_byte(8'($urandom));
                items_moved++;
            end
        end
    endtask

    // -------------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------------

    // byte registers on both sides, forced pointer bit, mode mask, dropped requests
    task automatic test_register_access();
        write_reg(REG_SELECT, 8'hFF);           // odd select steers to destination
        write_reg(REG_PTR_LO, 8'hFF);
        write_reg(REG_PTR_HI, 8'h00);           // reads back as 0x80
        read_reg(REG_PTR_HI);
        write_reg(REG_PTR_HI, 8'hFF);
        write_reg(REG_BANK_LO, 8'hFF);
        write_reg(REG_BANK_HI, 8'hFF);
        read_reg(REG_BANK_HI);
        write_reg(REG_SELECT, SEL_SRC);
        write_reg(REG_PTR_LO, 8'h00);
        write_reg(REG_PTR_HI, 8'h00);
        read_reg(REG_PTR_LO);
        write_reg(REG_MODE, 8'hFF);             // top two bits do not stick
        read_reg(REG_MODE);
        write_reg(REG_COUNT_LO, 8'h00);
        read_reg(REG_SELECT);
        read_reg(REG_COUNT_LO);
        issue_request(ACT_UNUSED, REG_SELECT, 8'hFF, 8'hFF);
        return_byte(8'hFF);                     // nothing outstanding, dropped
        wait_drained();
    endtask

    // one transfer per logic function, each with a different pair of pointer
    // modes; destination starts at 0xffff so its bank rolls over
    task automatic test_logic_functions();
        logic [1:0] src_modes[4] = '{PMODE_RELOAD, PM_CONTINUE, PM_FIXED_ALT, PM_FIXED};
        logic [1:0] dst_modes[4] = '{PM_CONTINUE, PM_FIXED, PMODE_RELOAD, PM_CONTINUE};
        logic [7:0] src_bytes[4] = '{8'hFF, 8'hA5, 8'h0F, 8'hFF};
        logic [7:0] dst_bytes[4] = '{8'h00, 8'h5A, 8'hF0, 8'h00};
        for (int op = 0; op < 4; op++) begin
            write_reg(REG_MODE, mode_byte(2'(op), dst_modes[op], src_modes[op]));
            write_reg(REG_COUNT_HI, 8'h00);
            return_byte(src_bytes[op]);
            // register requests in the middle of a run are dropped
            case (op)
                0:       read_reg(REG_COUNT_LO);
                1:       write_reg(REG_SELECT, SEL_DST);
                2:       issue_request(ACT_UNUSED, REG_MODE, 8'h00, 8'h00);
                default: write_reg(REG_COUNT_HI, 8'h00);
            endcase
            return_byte(dst_bytes[op]);
        end
        // two back to back transfers: write is followed by the next source read
        write_reg(REG_COUNT_LO, 8'h01);
        run_transfers(8'h00, 0);
        write_reg(REG_SELECT, SEL_DST);
        read_reg(REG_PTR_HI);
        read_reg(REG_BANK_LO);
        wait_drained();
    endtask

    // hold the sink long enough for the block to back up onto its input,
    // then let the sender pause until everything has come out
    task automatic test_result_backpressure();
        quiet            = 1'b1;
        hold_results_req = 1'b1;
        while (!hold_active) @(posedge aclk);
        for (int i = 0; i < 24; i++) read_reg(3'(i));
        quiet = 1'b0;
        wait_drained();
    endtask

    // mostly well formed runs with random set-up, plus idle noise
    task automatic test_random_traffic();
        int start_count;
        start_count = items_moved;
        while (items_moved - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 80) begin
                for (int side = 0; side < 2; side++) begin
                    if ($urandom_range(0, 1)) begin
                        write_reg(REG_SELECT, {7'($urandom), side[0]});
                        write_reg(REG_PTR_LO, ($urandom_range(0, 2) == 0) ?
                                  8'($urandom_range(248, 255)) : 8'($urandom));
                        // bias towards the top of the window so pointers wrap
                        write_reg(REG_PTR_HI, ($urandom_range(0, 1) == 0) ?
                                  8'hFF : 8'($urandom));
                        if ($urandom_range(0, 2) == 0) begin
                            write_reg(REG_BANK_LO, 8'($urandom));
                            write_reg(REG_BANK_HI, 8'($urandom));
                            items_moved += 2;
                        end
                        items_moved += 3;
                    end
                end
                write_reg(REG_MODE, 8'($urandom));
                write_reg(REG_COUNT_LO, ($urandom_range(0, 19) == 0) ?
                          8'($urandom_range(0, 63)) : 8'($urandom_range(0, 5)));
                items_moved += 2;
                run_transfers(8'h00, 8);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        read_reg(3'($urandom));
                        items_moved++;
                    end
                    1: begin
                        write_reg(3'($urandom_range(0, 6)), 8'($urandom));
                        items_moved++;
                    end
                    2:       issue_request(ACT_UNUSED, 3'($urandom), 8'($urandom),
                                           8'($urandom));
                    default: return_byte(8'($urandom));
                endcase
            end
        end
        wait_drained();
    endtask

    // a run long enough for the source pointer to wrap past 0xffff and roll
    // its bank over from 0xffff; destination reloads at the end
    task automatic test_long_transfer();
        quiet = 1'b1;
        write_reg(REG_SELECT, SEL_SRC);
        write_reg(REG_PTR_LO, 8'hF0);
        write_reg(REG_PTR_HI, 8'hFF);
        write_reg(REG_BANK_LO, 8'hFF);
        write_reg(REG_BANK_HI, 8'hFF);
        write_reg(REG_SELECT, SEL_DST);
        write_reg(REG_PTR_LO, 8'h00);
        write_reg(REG_PTR_HI, 8'h80);
        write_reg(REG_MODE, mode_byte(FN_XOR, PMODE_RELOAD, PM_CONTINUE));
        write_reg(REG_COUNT_LO, 8'h20);
        run_transfers(8'h00, 0);
        quiet = 1'b0;
        // destination should be back at its start, source well advanced
        read_reg(REG_PTR_LO);
        read_reg(REG_PTR_HI);
        write_reg(REG_SELECT, SEL_SRC);
        read_reg(REG_PTR_LO);
        read_reg(REG_PTR_HI);
        read_reg(REG_BANK_LO);
        read_reg(REG_BANK_HI);
        read_reg(REG_COUNT_HI);
        wait_drained();
    endtask

    // -------------------------------------------------------------------------
    // sequence
    // -------------------------------------------------------------------------
    initial begin : stimulus
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_action     = ACT_WRITE;
        s_reg_index  = REG_SELECT;
        s_write_byte = 8'h00;
        s_mem_byte   = 8'h00;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_register_access();
        test_logic_functions();
        test_result_backpressure();
        test_random_traffic();
        test_long_transfer();

        // everything owed has arrived; give stray results time to show
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && dma_results_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            if (dma_results_due.size() != 0)
                $error("%0d results never arrived", dma_results_due.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bdl_pkg.sv
hdl/bdl_core.sv
hdl/bdl_out_fifo.sv
hdl/byte_dma_with_logic_ops_unit.sv
verif/tb_byte_dma_with_logic_ops_unit.sv
